>>> rtl/core/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; pulled in by include where a module checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_IMP(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// next-cycle implication under reset
`define ASSERT_NXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

>>> rtl/core/gdrh_pkg.sv
// shared constants, types and tables for the godunov reinit pipeline
// no dependencies
`default_nettype none
package gdrh_pkg;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [29:0] PI_Q28  = 30'd843314857;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [30:0] Q30_ONE = 31'h40000000;
	localparam logic [17:0] SIGN_MAX = 18'd131071;

	localparam int ISQ_LAT      = 32;
	localparam int DIV1_QB      = 33;
	localparam int DIV2_QB      = 30;
	localparam int CNT_STEPS    = 6;
	localparam int TAYLOR_TERMS = 14;
	localparam int EXP_LAT      = CNT_STEPS + 3 * TAYLOR_TERMS + 1;

	typedef enum logic [0:0] {
		CFG_ETA_SCALE = 1'b0,
		CFG_THREE_D   = 1'b1
	} cfg_idx_t;

	// side data from the square stages across the root unit
	typedef struct packed {
		logic               v;
		logic               neg;
		logic               zero;
		logic signed [17:0] ss;
		logic [31:0]        phi_mag;
	} side_a_t;

	// side data across the divide / exp / divide section
	typedef struct packed {
		logic        v;
		logic        neg;
		logic        zero;
		logic        big;
		logic        dz;
		logic [30:0] mag;
		logic [31:0] ham;
	} side_b_t;

	// floor(2^30 / k) for the taylor term divide
	function automatic logic [30:0] taylor_recip(input int k);
		logic [30:0] m;
		case (k)
			1:       m = 31'd1073741824;
			2:       m = 31'd536870912;
			3:       m = 31'd357913941;
			4:       m = 31'd268435456;
			5:       m = 31'd214748364;
			6:       m = 31'd178956970;
			7:       m = 31'd153391689;
			8:       m = 31'd134217728;
			9:       m = 31'd119304647;
			10:      m = 31'd107374182;
			11:      m = 31'd97612893;
			12:      m = 31'd89478485;
			13:      m = 31'd82595524;
			14:      m = 31'd76695844;
			default: m = 31'd0;
		endcase
		return m;
	endfunction
endpackage
`default_nettype wire

>>> rtl/core/gdrh_delay.sv
// enabled delay line for side data that rides along a long unit
// no dependencies
`default_nettype none
module gdrh_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic [W-1:0] din,
	output logic      [W-1:0] dout
);
	logic [W-1:0] tap_s [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) tap_s[i] <= '0;
		end else if (en) begin
			tap_s[0] <= din;
			for (int i = 1; i < DEPTH; i++) tap_s[i] <= tap_s[i-1];
		end
	end

	assign dout = tap_s[DEPTH-1];
endmodule
`default_nettype wire

>>> rtl/core/gdrh_isqrt.sv
// pipelined 64-bit integer square root, one result bit per stage
// no dependencies
`default_nettype none
module gdrh_isqrt (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] radicand,
	output logic      [31:0] root
);
	logic [63:0] v_s   [0:32];
	logic [63:0] res_s [0:32];

	assign v_s[0]   = radicand;
	assign res_s[0] = '0;

	for (genvar i = 0; i < 32; i++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		logic [63:0] trial;
		assign trial = res_s[i] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (v_s[i] >= trial) begin
					v_s[i+1]   <= v_s[i] - trial;
					res_s[i+1] <= (res_s[i] >> 1) + BIT;
				end else begin
					v_s[i+1]   <= v_s[i];
					res_s[i+1] <= res_s[i] >> 1;
				end
			end
		end
	end

	assign root = res_s[32][31:0];
endmodule
`default_nettype wire

>>> rtl/core/gdrh_div.sv
// pipelined restoring divider, one quotient bit per stage
// starting remainder must be below the divisor; shin bits are shifted in msb first
`default_nettype none
module gdrh_div #(
	parameter int DW = 62,
	parameter int QB = 33
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [DW-1:0] rem0,
	input  wire logic [QB-1:0] shin,
	input  wire logic [DW-1:0] divisor,
	output logic      [QB-1:0] quo
);
	logic [DW-1:0] rem_s [0:QB];
	logic [QB-1:0] sh_s  [0:QB];
	logic [QB-1:0] q_s   [0:QB];
	logic [DW-1:0] d_s   [0:QB];

	assign rem_s[0] = rem0;
	assign sh_s[0]  = shin;
	assign q_s[0]   = '0;
	assign d_s[0]   = divisor;

	for (genvar i = 0; i < QB; i++) begin : g_step
		logic [DW:0] trial;
		logic        ge;
		assign trial = {rem_s[i], sh_s[i][QB-1]};
		assign ge    = trial >= {1'b0, d_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? DW'(trial - {1'b0, d_s[i]}) : trial[DW-1:0];
				sh_s[i+1]  <= sh_s[i] << 1;
				q_s[i+1]   <= {q_s[i][QB-2:0], ge};
				d_s[i+1]   <= d_s[i];
			end
		end
	end

	assign quo = q_s[QB];
endmodule
`default_nettype wire

>>> rtl/core/gdrh_exp.sv
// pipelined exp(-y) in q30: ln2 range reduction, taylor series, final shift
// depends on gdrh_pkg for constants and the reciprocal table
`default_nettype none
module gdrh_exp (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [35:0] y,
	output logic      [30:0] e
);
	import gdrh_pkg::*;

	localparam int NT = TAYLOR_TERMS;

	logic [35:0] crem_s [0:CNT_STEPS];
	logic [5:0]  ccnt_s [0:CNT_STEPS];

	logic signed [32:0] sum_c  [0:NT];
	logic [30:0]        term_c [0:NT];
	logic [29:0]        r_c    [0:NT];
	logic [5:0]         cnt_c  [0:NT];

	logic [29:0]        t_a   [1:NT];
	logic signed [32:0] sum_a [1:NT];
	logic [29:0]        r_a   [1:NT];
	logic [5:0]         cnt_a [1:NT];

	logic [29:0]        qe_b  [1:NT];
	logic [29:0]        t_b   [1:NT];
	logic signed [32:0] sum_b [1:NT];
	logic [29:0]        r_b   [1:NT];
	logic [5:0]         cnt_b [1:NT];

	logic [30:0] e_s;

	assign crem_s[0] = y;
	assign ccnt_s[0] = '0;

	// count of ln2 steps, one quotient bit per stage
	for (genvar j = 0; j < CNT_STEPS; j++) begin : g_cnt
		localparam int K = CNT_STEPS - 1 - j;
		localparam logic [35:0] LN2_K = {6'b0, LN2_Q30} << K;
		logic ge;
		assign ge = crem_s[j] >= LN2_K;
		always_ff @(posedge clk) begin
			if (en) begin
				crem_s[j+1] <= ge ? crem_s[j] - LN2_K : crem_s[j];
				ccnt_s[j+1] <= {ccnt_s[j][4:0], ge};
			end
		end
	end

	assign sum_c[0]  = $signed({2'b0, Q30_ONE});
	assign term_c[0] = Q30_ONE;
	assign r_c[0]    = crem_s[CNT_STEPS][29:0];
	assign cnt_c[0]  = ccnt_s[CNT_STEPS];

	// term k: multiply by r, divide by k through a reciprocal, then correct
	for (genvar i = 0; i < NT; i++) begin : g_term
		localparam int K = i + 1;
		localparam logic [30:0] RECIP = taylor_recip(K);
		localparam bit ODD = (K % 2) == 1;
		logic [60:0] prod_a;
		logic [60:0] prod_b;
		logic [33:0] qk;
		logic [33:0] rem;
		logic [29:0] q;
		assign prod_a = 61'(term_c[i]) * 61'(r_c[i]);
		assign prod_b = 61'(t_a[K]) * 61'(RECIP);
		assign qk     = 34'(qe_b[K]) * 34'(K);
		assign rem    = 34'(t_b[K]) - qk;
		assign q      = qe_b[K] + 30'(rem >= 34'(K));
		always_ff @(posedge clk) begin
			if (en) begin
				t_a[K]   <= prod_a[59:30];
				sum_a[K] <= sum_c[i];
				r_a[K]   <= r_c[i];
				cnt_a[K] <= cnt_c[i];

				qe_b[K]  <= prod_b[59:30];
				t_b[K]   <= t_a[K];
				sum_b[K] <= sum_a[K];
				r_b[K]   <= r_a[K];
				cnt_b[K] <= cnt_a[K];

				sum_c[K]  <= ODD ? sum_b[K] - $signed({3'b0, q})
				                 : sum_b[K] + $signed({3'b0, q});
				term_c[K] <= {1'b0, q};
				r_c[K]    <= r_b[K];
				cnt_c[K]  <= cnt_b[K];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) e_s <= sum_c[NT][30:0] >> cnt_c[NT];
	end

	assign e = e_s;
endmodule
`default_nettype wire

>>> rtl/core/godunov_reinit_hamiltonian_top.sv
// godunov gradient magnitude, tanh smoothed sign and reinit hamiltonian
// depends on gdrh_pkg, gdrh_delay, gdrh_isqrt, gdrh_div, gdrh_exp, assert_macros.svh
//
// channel   direction  handshake                 payload
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
// item      in         item_valid / item_stall   gradients, level_value, stored_sign
// result    out        result_valid / result_stall  grad_magnitude, smoothed_sign, hamiltonian
//
// one item per cycle unless result_stall freezes the pipeline; the depth is set by the root
// unit (32 stages), the ratio divider (33), the exp unit (49) and the tanh divider (30).
// while result_valid is high, result_stall freezes the whole pipeline in place and item_stall
// is raised. reset clears all valid bits; eta_scale resets to one, the z axis is off.
`default_nettype none
`include "assert_macros.svh"
module godunov_reinit_hamiltonian_top #(
	parameter int FRAC_BITS = gdrh_pkg::FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire gdrh_pkg::cfg_idx_t  cfg_index,
	input  wire logic [31:0]         cfg_data,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire logic signed [31:0]  grad_x_left,
	input  wire logic signed [31:0]  grad_x_right,
	input  wire logic signed [31:0]  grad_y_left,
	input  wire logic signed [31:0]  grad_y_right,
	input  wire logic signed [31:0]  grad_z_left,
	input  wire logic signed [31:0]  grad_z_right,
	input  wire logic signed [31:0]  level_value,
	input  wire logic signed [17:0]  stored_sign,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output logic [30:0]              grad_magnitude,
	output logic signed [17:0]       smoothed_sign,
	output logic signed [31:0]       hamiltonian
);
	import gdrh_pkg::*;

	localparam int NW  = 32 + FRAC_BITS;
	localparam int NHW = NW - 3;
	localparam int SIDE_B_LAT = DIV1_QB + 2 + EXP_LAT + 1 + DIV2_QB;
	localparam logic [32:0] ONE33 = 33'd1 << FRAC_BITS;
	localparam logic [30:0] ONE31 = 31'd1 << FRAC_BITS;
	localparam logic [50:0] HALF  = 51'd1 << (FRAC_BITS - 1);
	localparam logic [30:0] RND   = 31'd1 << (29 - FRAC_BITS);
	localparam logic [34:0] X_MAX = 35'd16 << 30;

	function automatic logic [31:0] axis_mag(input logic signed [31:0] l,
	                                         input logic signed [31:0] r, input logic pos);
		logic [31:0] a;
		logic [31:0] b;
		if (pos) begin
			a = l[31] ? 32'(-l) : 32'd0;
			b = r[31] ? 32'd0 : 32'(r);
		end else begin
			a = l[31] ? 32'd0 : 32'(l);
			b = r[31] ? 32'(-r) : 32'd0;
		end
		return (a > b) ? a : b;
	endfunction

	logic        adv;
	logic [30:0] eta_q;
	logic        three_d_q;

	logic        pos_c;
	side_a_t     sa_c;
	side_a_t     sa_s1, sa_s2, sa_s3, sa_dly, sa_s4;
	logic [31:0] mx_s1, my_s1, mz_s1;
	logic [63:0] sqx_s2, sqy_s2, sqz_s2;
	logic [63:0] sum_s3;
	logic [31:0] root;
	logic [30:0] mag_s4;

	logic               v_s5, neg_s5, zero_s5;
	logic [30:0]        mag_s5;
	logic [61:0]        d_s5;
	logic signed [50:0] hp_s5;
	logic [NHW-1:0]     n_hi_s5;
	logic [2:0]         n_lo_s5;
	logic [NW-1:0]      n_c;
	logic signed [32:0] diff_c;

	side_b_t        sb_c, sb_s6, sb_dly;
	logic [61:0]    d_s6;
	logic [NHW-1:0] n_hi_s6;
	logic [2:0]     n_lo_s6;
	logic [50:0]    habs_c;
	logic [50:0]    hr_c;
	logic [31:0]    ham_c;

	logic [32:0] ratio;
	logic [62:0] xprod_c;
	logic [34:0] x_s7;
	logic [35:0] y_s8;
	logic [30:0] e;
	logic [31:0] num_s9, den_s9;
	logic [29:0] t;

	logic [30:0]        tr_c, tmag_c, smag_c;
	logic [17:0]        sclamp_c;
	logic               v_s10;
	logic [30:0]        mag_s10;
	logic signed [17:0] sgn_s10;
	logic signed [31:0] ham_s10;

	assign adv        = !v_s10 || !result_stall;
	assign item_stall = !adv;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_q     <= 31'd65536;
			three_d_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ETA_SCALE: eta_q     <= cfg_data[30:0];
				CFG_THREE_D:   three_d_q <= cfg_data[0];
			endcase
		end
	end

	// stage 1: clipped one-sided magnitudes per axis
	assign pos_c = !level_value[31] && (level_value != 32'sd0);
	always_comb begin
		sa_c.v       = item_valid;
		sa_c.neg     = level_value[31];
		sa_c.zero    = level_value == 32'sd0;
		sa_c.ss      = stored_sign;
		sa_c.phi_mag = level_value[31] ? 32'(-level_value) : 32'(level_value);
	end

	// control (valid-carrying) registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sa_s1 <= '0;
			sa_s2 <= '0;
			sa_s3 <= '0;
			sa_s4 <= '0;
			v_s5  <= 1'b0;
			sb_s6 <= '0;
			v_s10 <= 1'b0;
		end else if (adv) begin
			sa_s1 <= sa_c;
			sa_s2 <= sa_s1;
			sa_s3 <= sa_s2;
			sa_s4 <= sa_dly;
			v_s5  <= sa_s4.v;
			sb_s6 <= sb_c;
			v_s10 <= sb_dly.v;
		end
	end

	assign diff_c = $signed({2'b0, mag_s4}) - $signed(ONE33);
	assign n_c    = {sa_s4.phi_mag, FRAC_BITS'(0)};

	always_comb begin
		habs_c = hp_s5[50] ? 51'(-hp_s5) : 51'(hp_s5);
		hr_c   = (habs_c + HALF) >> FRAC_BITS;
		if (hp_s5[50]) begin
			ham_c = (hr_c > 51'h80000000) ? 32'h80000000 : 32'(-hr_c[31:0]);
		end else begin
			ham_c = (hr_c > 51'h7fffffff) ? 32'h7fffffff : hr_c[31:0];
		end
		sb_c.v    = v_s5;
		sb_c.neg  = neg_s5;
		sb_c.zero = zero_s5;
		sb_c.big  = 62'(n_hi_s5) >= d_s5;
		sb_c.dz   = d_s5 == 62'd0;
		sb_c.mag  = mag_s5;
		sb_c.ham  = ham_c;
	end

	assign xprod_c = 63'(ratio) * 63'(PI_Q28);

	// final tanh rounding and sign assembly
	always_comb begin
		tr_c   = (31'(t) + RND) >> (30 - FRAC_BITS);
		tmag_c = (tr_c > ONE31) ? ONE31 : tr_c;
		if (sb_dly.zero) smag_c = '0;
		else if (sb_dly.dz || sb_dly.big) smag_c = ONE31;
		else smag_c = tmag_c;
		sclamp_c = (smag_c > 31'(SIGN_MAX)) ? SIGN_MAX : smag_c[17:0];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s1 <= axis_mag(grad_x_left, grad_x_right, pos_c);
			my_s1 <= axis_mag(grad_y_left, grad_y_right, pos_c);
			mz_s1 <= three_d_q ? axis_mag(grad_z_left, grad_z_right, pos_c) : 32'd0;

			sqx_s2 <= 64'(mx_s1) * 64'(mx_s1);
			sqy_s2 <= 64'(my_s1) * 64'(my_s1);
			sqz_s2 <= 64'(mz_s1) * 64'(mz_s1);

			sum_s3 <= sqx_s2 + sqy_s2 + sqz_s2;

			mag_s4 <= root[31] ? 31'h7fffffff : root[30:0];

			neg_s5  <= sa_s4.neg;
			zero_s5 <= sa_s4.zero;
			mag_s5  <= mag_s4;
			d_s5    <= 62'(eta_q) * 62'(mag_s4);
			hp_s5   <= 51'(diff_c) * 51'($signed(sa_s4.ss));
			n_hi_s5 <= n_c[NW-1:3];
			n_lo_s5 <= n_c[2:0];

			d_s6    <= d_s5;
			n_hi_s6 <= n_hi_s5;
			n_lo_s6 <= n_lo_s5;

			x_s7 <= xprod_c[62:28];
			y_s8 <= (x_s7 > X_MAX) ? {X_MAX, 1'b0} : {x_s7, 1'b0};

			num_s9 <= 32'(Q30_ONE) - 32'(e);
			den_s9 <= 32'(Q30_ONE) + 32'(e);

			mag_s10 <= sb_dly.mag;
			ham_s10 <= sb_dly.ham;
			sgn_s10 <= sb_dly.neg ? 18'(-sclamp_c) : sclamp_c;
		end
	end

	gdrh_isqrt u_isqrt (
		.clk      (clk),
		.en       (adv),
		.radicand (sum_s3),
		.root     (root)
	);

	gdrh_delay #(.W($bits(side_a_t)), .DEPTH(ISQ_LAT)) u_side_a (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.din    (sa_s3),
		.dout   (sa_dly)
	);

	// ratio = |phi| * 2^(frac+30) / (eta * mag), three integer bits
	gdrh_div #(.DW(62), .QB(DIV1_QB)) u_div_ratio (
		.clk     (clk),
		.en      (adv),
		.rem0    (62'(n_hi_s6)),
		.shin    ({n_lo_s6, 30'd0}),
		.divisor (d_s6),
		.quo     (ratio)
	);

	gdrh_exp u_exp (
		.clk (clk),
		.en  (adv),
		.y   (y_s8),
		.e   (e)
	);

	// tanh = (1 - e) / (1 + e) in q30
	gdrh_div #(.DW(32), .QB(DIV2_QB)) u_div_tanh (
		.clk     (clk),
		.en      (adv),
		.rem0    (num_s9),
		.shin    ('0),
		.divisor (den_s9),
		.quo     (t)
	);

	gdrh_delay #(.W($bits(side_b_t)), .DEPTH(SIDE_B_LAT)) u_side_b (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.din    (sb_s6),
		.dout   (sb_dly)
	);

	assign result_valid   = v_s10;
	assign grad_magnitude = mag_s10;
	assign smoothed_sign  = sgn_s10;
	assign hamiltonian    = ham_s10;

	`ASSERT_NXT(a_accept_enters, clk, arst_n, item_valid && !item_stall, sa_s1.v)
	`ASSERT_IMP(a_sign_not_min, clk, arst_n, result_valid, smoothed_sign != 18'sh20000)
	`ASSERT_IMP(a_divisor_covers_mag, clk, arst_n, sb_s6.v && !sb_s6.dz,
		d_s6 >= 62'(sb_s6.mag))
endmodule
`default_nettype wire
